>>> design/mwm_pkg.sv
package mwm_pkg;

  localparam int CMD_WIDTH   = 16;
  localparam int PULSE_WIDTH = 12;
  localparam int SPAN_W      = 16;
  localparam int SPAN_FRAC   = 12;
  localparam int UNIT_LOG2   = 26;
  localparam int WHEELS      = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int HALF_SPAN_RST = 4096;
  localparam int MAX_PULSE_RST = 4095;
  localparam int MIN_PULSE_RST = 0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_SPAN = 2'd0,
    REG_MAX_PULSE = 2'd1,
    REG_MIN_PULSE = 2'd2
  } cfg_reg_e;

endpackage

>>> design/mwm_if.sv
interface mwm_cmd_if #(
  parameter int CMD_WIDTH = mwm_pkg::CMD_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic [CMD_WIDTH-1:0] x_cmd;
  logic [CMD_WIDTH-1:0] y_cmd;
  logic [CMD_WIDTH-1:0] turn_cmd;

  modport source (output valid, x_cmd, y_cmd, turn_cmd, input ready);
  modport sink   (input valid, x_cmd, y_cmd, turn_cmd, output ready);
endinterface

interface mwm_pulse_if #(
  parameter int PULSE_WIDTH = mwm_pkg::PULSE_WIDTH
);
  logic                   valid;
  logic                   ready;
  logic [PULSE_WIDTH-1:0] front_left_fwd;
  logic [PULSE_WIDTH-1:0] front_left_rev;
  logic [PULSE_WIDTH-1:0] front_right_fwd;
  logic [PULSE_WIDTH-1:0] front_right_rev;
  logic [PULSE_WIDTH-1:0] rear_left_fwd;
  logic [PULSE_WIDTH-1:0] rear_left_rev;
  logic [PULSE_WIDTH-1:0] rear_right_fwd;
  logic [PULSE_WIDTH-1:0] rear_right_rev;

  modport source (output valid, front_left_fwd, front_left_rev, front_right_fwd,
                  front_right_rev, rear_left_fwd, rear_left_rev, rear_right_fwd,
                  rear_right_rev, input ready);
  modport sink   (input valid, front_left_fwd, front_left_rev, front_right_fwd,
                  front_right_rev, rear_left_fwd, rear_left_rev, rear_right_fwd,
                  rear_right_rev, output ready);
endinterface

interface mwm_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mwm_pkg::CFG_IDX_W-1:0]      index;
  logic [mwm_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/mwm_kin.sv
module mwm_kin #(
  parameter int CMD_WIDTH = mwm_pkg::CMD_WIDTH,
  localparam int VW = CMD_WIDTH + mwm_pkg::SPAN_W + 1,
  localparam int MW = CMD_WIDTH + mwm_pkg::SPAN_W,
  localparam int DW = (MW > mwm_pkg::UNIT_LOG2 + 1) ? MW : mwm_pkg::UNIT_LOG2 + 1
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [CMD_WIDTH-1:0]                  x_i,
  input  logic [CMD_WIDTH-1:0]                  y_i,
  input  logic [CMD_WIDTH-1:0]                  t_i,
  input  logic [mwm_pkg::SPAN_W-1:0]            half_span_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [mwm_pkg::WHEELS-1:0][MW-1:0]    mag_o,
  output logic [mwm_pkg::WHEELS-1:0]            neg_o,
  output logic [DW-1:0]                         dnm_o
);

  localparam int W = mwm_pkg::WHEELS;
  localparam logic [DW-1:0] UNIT = DW'(1) << mwm_pkg::UNIT_LOG2;

  logic [2:0] vld_q;
  logic [2:0] rdy;

  logic signed [VW-1:0] sum_q, dif_q, rot_q;
  logic signed [VW-1:0] v [W];
  logic signed [VW-1:0] absv [W];
  logic [W-1:0][MW-1:0] mag1_q, mag2_q;
  logic [W-1:0]         neg1_q, neg2_q;
  logic [MW-1:0]        top01, top23, top;
  logic [DW-1:0]        dnm_d, dnm_q;

  assign rdy[2] = !vld_q[2] || out_ready_i;
  assign rdy[1] = !vld_q[1] || rdy[2];
  assign rdy[0] = !vld_q[0] || rdy[1];
  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      if (rdy[1]) vld_q[1] <= vld_q[0];
      if (rdy[2]) vld_q[2] <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      sum_q <= VW'($signed({x_i[CMD_WIDTH-1], x_i}) + $signed({y_i[CMD_WIDTH-1], y_i}))
               <<< mwm_pkg::SPAN_FRAC;
      dif_q <= VW'($signed({y_i[CMD_WIDTH-1], y_i}) - $signed({x_i[CMD_WIDTH-1], x_i}))
               <<< mwm_pkg::SPAN_FRAC;
      rot_q <= VW'($signed(t_i)) * VW'($signed({1'b0, half_span_i}));
    end
  end

  always_comb begin
    v[0] = sum_q + rot_q;
    v[1] = dif_q - rot_q;
    v[2] = dif_q + rot_q;
    v[3] = sum_q - rot_q;
    for (int w = 0; w < W; w++) begin
      absv[w] = v[w][VW-1] ? -v[w] : v[w];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1] && vld_q[0]) begin
      for (int w = 0; w < W; w++) begin
        mag1_q[w] <= absv[w][MW-1:0];
        neg1_q[w] <= v[w][VW-1];
      end
    end
  end

  always_comb begin
    top01 = (mag1_q[0] > mag1_q[1]) ? mag1_q[0] : mag1_q[1];
    top23 = (mag1_q[2] > mag1_q[3]) ? mag1_q[2] : mag1_q[3];
    top   = (top01 > top23) ? top01 : top23;
    dnm_d = (DW'(top) > UNIT) ? DW'(top) : UNIT;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2] && vld_q[1]) begin
      mag2_q <= mag1_q;
      neg2_q <= neg1_q;
      dnm_q  <= dnm_d;
    end
  end

  assign mag_o = mag2_q;
  assign neg_o = neg2_q;
  assign dnm_o = dnm_q;

endmodule

>>> design/mwm_div.sv
module mwm_div #(
  parameter int MW = 32,
  parameter int DW = 32,
  parameter int PULSE_WIDTH = mwm_pkg::PULSE_WIDTH
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic [mwm_pkg::WHEELS-1:0][MW-1:0]         mag_i,
  input  logic [mwm_pkg::WHEELS-1:0]                 neg_i,
  input  logic [DW-1:0]                              dnm_i,
  input  logic [PULSE_WIDTH-1:0]                     max_pulse_i,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output logic [mwm_pkg::WHEELS-1:0][PULSE_WIDTH-1:0] quo_o,
  output logic [mwm_pkg::WHEELS-1:0]                 neg_o
);

  localparam int W  = mwm_pkg::WHEELS;
  localparam int PW = PULSE_WIDTH;
  localparam int AW = DW + 1;
  localparam int NW = AW + PW;
  localparam int NS = PW + 2;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] rdy;

  logic [AW-1:0] num_q [W];
  logic [AW-1:0] den_q [NS];
  logic [W-1:0]  neg_q [NS];
  logic [NW-1:0] rem_q [NS][W];
  logic [PW-1:0] quo_q [NS][W];

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_ctl
    if (k == NS - 1) begin : g_last
      assign rdy[k] = !vld_q[k] || out_ready_i;
    end else begin : g_mid
      assign rdy[k] = !vld_q[k] || rdy[k+1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      for (int w = 0; w < W; w++) begin
        num_q[w] <= AW'(mag_i[w]) + AW'(dnm_i);
      end
      den_q[0] <= {dnm_i, 1'b0};
      neg_q[0] <= neg_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1] && vld_q[0]) begin
      for (int w = 0; w < W; w++) begin
        rem_q[1][w] <= NW'(num_q[w]) * NW'(max_pulse_i);
        quo_q[1][w] <= '0;
      end
      den_q[1] <= den_q[0];
      neg_q[1] <= neg_q[0];
    end
  end

  for (genvar s = 2; s < NS; s++) begin : g_stage
    localparam int J = NS - 1 - s;
    logic [NW-1:0] sh;
    assign sh = {{PW{1'b0}}, den_q[s-1]} << J;
    always_ff @(posedge clk_i) begin
      if (rdy[s] && vld_q[s-1]) begin
        for (int w = 0; w < W; w++) begin
          if (rem_q[s-1][w] >= sh) begin
            rem_q[s][w] <= rem_q[s-1][w] - sh;
            quo_q[s][w] <= quo_q[s-1][w] | (PW'(1) << J);
          end else begin
            rem_q[s][w] <= rem_q[s-1][w];
            quo_q[s][w] <= quo_q[s-1][w];
          end
        end
        den_q[s] <= den_q[s-1];
        neg_q[s] <= neg_q[s-1];
      end
    end
  end

  always_comb begin
    for (int w = 0; w < W; w++) begin
      quo_o[w] = quo_q[NS-1][w];
    end
  end
  assign neg_o = neg_q[NS-1];

endmodule

>>> design/mecanum_wheel_mixer.sv
// Mecanum wheel mixer: turns a motion command (x, y, turn, 1.0 = 16384) into
// forward/reverse pulse counts for four wheels, normalizing when any wheel
// exceeds full speed. One item enters per cycle while the output is not
// stalled. The pipeline holds three mixing stages, an add and a multiply
// stage, one restoring-division stage per quotient bit, and the output
// register. Each stage has its own valid bit, so bubbles close up behind a
// stalled output. Configuration is applied to items in flight, so write it
// only while the block is empty.
module mecanum_wheel_mixer #(
  parameter int CMD_WIDTH   = mwm_pkg::CMD_WIDTH,
  parameter int PULSE_WIDTH = mwm_pkg::PULSE_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mwm_cfg_if.sink     cfg_i,
  mwm_cmd_if.sink     cmd_i,
  mwm_pulse_if.source pulse_o
);

  localparam int W  = mwm_pkg::WHEELS;
  localparam int PW = PULSE_WIDTH;
  localparam int MW = CMD_WIDTH + mwm_pkg::SPAN_W;
  localparam int DW = (MW > mwm_pkg::UNIT_LOG2 + 1) ? MW : mwm_pkg::UNIT_LOG2 + 1;

  logic [mwm_pkg::SPAN_W-1:0] half_span_q;
  logic [PW-1:0]              max_pulse_q, min_pulse_q;

  logic                 kin_valid, kin_ready;
  logic [W-1:0][MW-1:0] kin_mag;
  logic [W-1:0]         kin_neg;
  logic [DW-1:0]        kin_dnm;

  logic                 div_valid, div_ready;
  logic [W-1:0][PW-1:0] div_quo;
  logic [W-1:0]         div_neg;

  logic                 out_vld_q;
  logic [2*W-1:0][PW-1:0] pls_d, pls_q;
  logic [PW-1:0]        clp;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_span_q <= mwm_pkg::SPAN_W'(mwm_pkg::HALF_SPAN_RST);
      max_pulse_q <= PW'(mwm_pkg::MAX_PULSE_RST);
      min_pulse_q <= PW'(mwm_pkg::MIN_PULSE_RST);
    end else if (cfg_i.valid) begin
      case (mwm_pkg::cfg_reg_e'(cfg_i.index))
        mwm_pkg::REG_HALF_SPAN: half_span_q <= cfg_i.data;
        mwm_pkg::REG_MAX_PULSE: max_pulse_q <= PW'(cfg_i.data);
        mwm_pkg::REG_MIN_PULSE: min_pulse_q <= PW'(cfg_i.data);
        default: ;
      endcase
    end
  end

  mwm_kin #(.CMD_WIDTH(CMD_WIDTH)) u_kin (
    .clk_i,
    .rst_ni,
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .x_i         (cmd_i.x_cmd),
    .y_i         (cmd_i.y_cmd),
    .t_i         (cmd_i.turn_cmd),
    .half_span_i (half_span_q),
    .out_valid_o (kin_valid),
    .out_ready_i (kin_ready),
    .mag_o       (kin_mag),
    .neg_o       (kin_neg),
    .dnm_o       (kin_dnm)
  );

  mwm_div #(.MW(MW), .DW(DW), .PULSE_WIDTH(PW)) u_div (
    .clk_i,
    .rst_ni,
    .in_valid_i  (kin_valid),
    .in_ready_o  (kin_ready),
    .mag_i       (kin_mag),
    .neg_i       (kin_neg),
    .dnm_i       (kin_dnm),
    .max_pulse_i (max_pulse_q),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .quo_o       (div_quo),
    .neg_o       (div_neg)
  );

  assign div_ready = !out_vld_q || pulse_o.ready;

  always_comb begin
    clp = '0;
    for (int w = 0; w < W; w++) begin
      if (div_quo[w] < min_pulse_q) begin
        clp = min_pulse_q;
      end else if (div_quo[w] > max_pulse_q) begin
        clp = max_pulse_q;
      end else begin
        clp = div_quo[w];
      end
      pls_d[2*w]   = div_neg[w] ? '0 : clp;
      pls_d[2*w+1] = div_neg[w] ? clp : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (div_ready) begin
      out_vld_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_ready && div_valid) begin
      pls_q <= pls_d;
    end
  end

  assign pulse_o.valid           = out_vld_q;
  assign pulse_o.front_left_fwd  = pls_q[0];
  assign pulse_o.front_left_rev  = pls_q[1];
  assign pulse_o.front_right_fwd = pls_q[2];
  assign pulse_o.front_right_rev = pls_q[3];
  assign pulse_o.rear_left_fwd   = pls_q[4];
  assign pulse_o.rear_left_rev   = pls_q[5];
  assign pulse_o.rear_right_fwd  = pls_q[6];
  assign pulse_o.rear_right_rev  = pls_q[7];

endmodule
